>>> design/lmw_pkg.sv
// ----------------------------------------------------------------------------
// lmw_pkg: shared definitions for the luma median window filter
// Default geometry, field widths, register indexes, the pipeline tag and the
// luma weighting function.
// ----------------------------------------------------------------------------
package lmw_pkg;

  // Default geometry handed to the top level parameters.
  localparam int WIN_W_DEF     = 3;
  localparam int WIN_H_DEF     = 3;
  localparam int MAX_WIDTH_DEF = 2048;

  // Field and register widths.
  localparam int PIX_W  = 32;
  localparam int LUMA_W = 16;
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int CFG_DW = 13;
  localparam int CFG_IW = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the frame geometry registers.
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Tag that travels with a column fetch through the pipeline.
  typedef struct packed {
    logic fetch;     // a column is loaded into the window
    logic emit;      // this fetch completes a window that produces a result
    logic interior;  // the output position has a full window around it
    logic last;      // last output pixel of the frame
  } lmw_tag_t;

  // Luma as 77R + 150G + 29B; the largest value, 65280, fits in 16 bits.
  function automatic logic [LUMA_W-1:0] luma_f(input logic [PIX_W-1:0] p);
    logic [LUMA_W-1:0] r;
    logic [LUMA_W-1:0] g;
    logic [LUMA_W-1:0] b;
    r = {8'd0, p[31:24]};
    g = {8'd0, p[23:16]};
    b = {8'd0, p[15:8]};
    return LUMA_W'(16'd77 * r + 16'd150 * g + 16'd29 * b);
  endfunction

endpackage

>>> design/lmw_ram.sv
// ----------------------------------------------------------------------------
// lmw_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read; the read returns
// the contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module lmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/lmw_cell.sv
// ----------------------------------------------------------------------------
// lmw_cell: one window cell
// Holds one window pixel with its luma and passes both to its left neighbor
// whenever a new column shifts into the window.
// ----------------------------------------------------------------------------
module lmw_cell import lmw_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [PIX_W-1:0]  pix_in,
  input  logic [LUMA_W-1:0] luma_in,
  output logic [PIX_W-1:0]  pix_out,
  output logic [LUMA_W-1:0] luma_out
);

  logic [PIX_W-1:0]  pix_r;
  logic [LUMA_W-1:0] luma_r;

  // Take the neighbor's pixel on a shift, otherwise hold.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r  <= pix_in;
      luma_r <= luma_in;
    end
  end

  assign pix_out  = pix_r;
  assign luma_out = luma_r;

endmodule

>>> design/lmw_rank.sv
// ----------------------------------------------------------------------------
// lmw_rank: stable rank selection over the window
// Registers the pairwise luma ordering of all window cells, then picks the
// cell whose stable rank equals the middle rank, or the center pixel on a
// border position.
// ----------------------------------------------------------------------------
module lmw_rank import lmw_pkg::*; #(
  parameter int N      = 9,
  parameter int TARGET = 4,
  parameter int CENTER = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  lmw_tag_t                     tag_in,
  input  logic [N-1:0][PIX_W-1:0]      pix,
  input  logic [N-1:0][LUMA_W-1:0]     luma,
  output lmw_tag_t                     tag_out,
  output logic [PIX_W-1:0]             pix_out
);

  localparam int RK_W = $clog2(N + 1);

  logic [N-1:0][N-1:0]    ahead_nxt;
  logic [N-1:0][N-1:0]    ahead_r;
  logic [N-1:0][PIX_W-1:0] pix_r;
  lmw_tag_t               tag_r;
  logic [PIX_W-1:0]       sel;

  // Cell j ranks ahead of cell i if its luma is lower, or equal and earlier.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (j == i) begin
          ahead_nxt[i][j] = 1'b0;
        end else begin
          ahead_nxt[i][j] = (luma[j] < luma[i]) || ((luma[j] == luma[i]) && (j < i));
        end
      end
    end
  end

  // Comparison stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ahead_r <= ahead_nxt;
      pix_r   <= pix;
    end
  end

  // Count each cell's rank and select the one at the middle rank.
  always_comb begin
    logic [RK_W-1:0] cnt;
    sel = pix_r[CENTER];
    for (int i = 0; i < N; i++) begin
      cnt = '0;
      for (int j = 0; j < N; j++) begin
        cnt = cnt + RK_W'(ahead_r[i][j]);
      end
      if (tag_r.interior && (cnt == RK_W'(TARGET))) begin
        sel = pix_r[i];
      end
    end
  end

  assign tag_out = tag_r;
  assign pix_out = sel;

endmodule

>>> design/luma_median_window_filter.sv
// ----------------------------------------------------------------------------
// luma_median_window_filter: luma median filter over a sliding pixel window
// Pipeline: a result passes the fetch stage, the window cells, the rank register
//   and the output register on its way to out_tvalid; pixels themselves lag by
//   (WINDOW_H-1-WINDOW_H/2) rows plus (WINDOW_W-1-WINDOW_W/2) pixels.
// Throughput: one pixel per cycle while the output is not stalled; the window
//   refill after reset, after a configuration write or after a pixel that yields
//   no result holds in_tready low while the window columns are reloaded.
// Reset: synchronous; geometry returns to 640 x 480, counters clear, the line
//   store is not cleared.
// ----------------------------------------------------------------------------
module luma_median_window_filter import lmw_pkg::*; #(
  parameter int WINDOW_W  = WIN_W_DEF,
  parameter int WINDOW_H  = WIN_H_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // pixel_in [31:0]
  input  logic              in_tuser,   // is_flush [0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,  // pixel_out [31:0]
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int N        = WINDOW_W * WINDOW_H;
  localparam int EW_C     = WINDOW_W / 2;
  localparam int EH_C     = WINDOW_H / 2;
  localparam int HD       = WINDOW_H * MAX_WIDTH;
  localparam int AW       = $clog2(HD);
  localparam int PW       = $clog2(HD + 1);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = FH_W;
  localparam int SW       = AW + 2;
  localparam int PF_W     = $clog2(WINDOW_W + 1);
  localparam int TARGET   = EH_C * WINDOW_W + EW_C;
  localparam int LAG_ROWS = WINDOW_H - 1 - EH_C;
  localparam int LAG_COLS = WINDOW_W - 1 - EW_C;
  localparam int NEW_D    = WINDOW_W - 1 - EW_C;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [AW-1:0]    wr_r;
  logic [PW-1:0]    pending_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             win_ok_r;
  logic [PF_W-1:0]  pf_cnt_r;

  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [PW-1:0]    lag;
  logic             adv;
  logic             is_flush;
  logic             need_emit;
  logic             refill;
  logic             accept;
  logic             pf_issue;
  logic             emit_acc;
  logic             issue;
  logic             px_wr;
  logic [AW-1:0]    base;
  logic signed [SW-1:0] col_d;
  logic [WINDOW_H-1:0][AW-1:0] rd_addr;
  logic [WINDOW_H-1:0]         byp;
  logic             interior;
  logic             last;

  lmw_tag_t                        s1_tag_r;
  lmw_tag_t                        s2_tag_r;
  lmw_tag_t                        rk_tag;
  logic [WINDOW_H-1:0]             byp_r;
  logic [PIX_W-1:0]                bdata_r;
  logic [WINDOW_H-1:0][PIX_W-1:0]  ram_q;
  logic [WINDOW_H-1:0][PIX_W-1:0]  col_pix;
  logic [WINDOW_H-1:0][LUMA_W-1:0] col_luma;
  logic [N-1:0][PIX_W-1:0]         cell_in_pix;
  logic [N-1:0][LUMA_W-1:0]        cell_in_luma;
  logic [N-1:0][PIX_W-1:0]         cell_pix;
  logic [N-1:0][LUMA_W-1:0]        cell_luma;
  logic [PIX_W-1:0]                rk_pix;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  // Effective frame geometry and output lag.
  always_comb begin
    if (fw_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_r);
    end
    eff_h = (fh_r == '0) ? ROW_W'(1) : fh_r;
    lag   = PW'(32'(LAG_ROWS) * 32'(eff_w) + 32'(LAG_COLS));
  end

  // The whole pipeline moves while the output register can take a result.
  assign adv       = !out_valid_r || out_tready;
  assign is_flush  = in_tuser;
  assign need_emit = is_flush ? (pending_r != '0) : (pending_r >= lag);
  assign refill    = (WINDOW_W > 1) && !win_ok_r && need_emit;
  assign in_tready = adv && !refill;
  assign accept    = in_tvalid && in_tready;
  assign pf_issue  = adv && in_tvalid && refill;
  assign emit_acc  = accept && need_emit;
  assign issue     = pf_issue || emit_acc;
  assign px_wr     = accept && !is_flush;

  // Line store addresses of the column that enters the window.
  always_comb begin
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] kk;
    logic signed [SW-1:0] ww;
    b = SW'(wr_r) - SW'(pending_r);
    if (b < 0) begin
      b = b + SW'(HD);
    end
    base  = AW'(b);
    col_d = pf_issue ? (SW'(pf_cnt_r) - SW'(EW_C)) : SW'(NEW_D);
    ww    = SW'(eff_w);
    for (int k = 0; k < WINDOW_H; k++) begin
      kk = SW'(k - EH_C);
      a  = SW'(base) + kk * ww + col_d;
      if (a < 0) begin
        a = a + SW'(HD);
      end else if (a >= SW'(HD)) begin
        a = a - SW'(HD);
      end
      rd_addr[k] = AW'(a);
      byp[k]     = px_wr && (rd_addr[k] == wr_r);
    end
  end

  // Position class of the next output pixel.
  always_comb begin
    logic [31:0] c;
    logic [31:0] r;
    logic [31:0] w;
    logic [31:0] h;
    c = 32'(out_col_r);
    r = 32'(out_row_r);
    w = 32'(eff_w);
    h = 32'(eff_h);
    interior = (c >= 32'(EW_C)) && (c + 32'(EW_C) < w) &&
               (r >= 32'(EH_C)) && (r + 32'(EH_C) < h);
    last     = (c + 32'd1 >= w) && (r + 32'd1 >= h);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
        default:          fh_r <= fh_r;
      endcase
    end
  end

  // Write pointer, pending count and output position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r      <= '0;
      pending_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (px_wr) begin
        wr_r <= (wr_r == AW'(HD - 1)) ? '0 : wr_r + AW'(1);
      end
      if (accept) begin
        if (!is_flush && !need_emit) begin
          pending_r <= pending_r + PW'(1);
        end else if (is_flush && need_emit) begin
          pending_r <= pending_r - PW'(1);
        end
      end
      if (emit_acc) begin
        if (32'(out_col_r) + 32'd1 >= 32'(eff_w)) begin
          out_col_r <= '0;
          out_row_r <= (32'(out_row_r) + 32'd1 >= 32'(eff_h)) ? '0 :
                       out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Window refill tracking: a write that yields no result or a new geometry
  // can leave held columns stale, so the next result reloads the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_ok_r <= 1'b0;
      pf_cnt_r <= '0;
    end else if (cfg_we) begin
      win_ok_r <= 1'b0;
      pf_cnt_r <= '0;
    end else if (px_wr && !need_emit) begin
      win_ok_r <= 1'b0;
    end else if (pf_issue) begin
      if (pf_cnt_r == PF_W'(WINDOW_W - 2)) begin
        win_ok_r <= 1'b1;
        pf_cnt_r <= '0;
      end else begin
        pf_cnt_r <= pf_cnt_r + PF_W'(1);
      end
    end
  end

  // Line store: one copy per window row, each with its own read port.
  for (genvar k = 0; k < WINDOW_H; k++) begin : g_store
    lmw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (HD)
    ) u_ram (
      .clk     (clk),
      .wr_en   (px_wr),
      .wr_addr (wr_r),
      .wr_data (in_tdata),
      .rd_en   (issue),
      .rd_addr (rd_addr[k]),
      .rd_data (ram_q[k])
    );
  end

  // Fetch stage: tag and write bypass for the column in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else if (adv) begin
      s1_tag_r.fetch    <= issue;
      s1_tag_r.emit     <= emit_acc;
      s1_tag_r.interior <= interior;
      s1_tag_r.last     <= last;
      s2_tag_r.fetch    <= s1_tag_r.fetch;
      s2_tag_r.emit     <= s1_tag_r.fetch && s1_tag_r.emit;
      s2_tag_r.interior <= s1_tag_r.interior;
      s2_tag_r.last     <= s1_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_r   <= byp;
      bdata_r <= in_tdata;
    end
  end

  // Incoming column with its lumas.
  always_comb begin
    for (int k = 0; k < WINDOW_H; k++) begin
      col_pix[k]  = byp_r[k] ? bdata_r : ram_q[k];
      col_luma[k] = luma_f(col_pix[k]);
    end
  end

  // Window cells: each row shifts left, the new column enters on the right.
  for (genvar k = 0; k < WINDOW_H; k++) begin : g_row
    for (genvar j = 0; j < WINDOW_W; j++) begin : g_col
      if (j == WINDOW_W - 1) begin : g_edge
        assign cell_in_pix[k*WINDOW_W+j]  = col_pix[k];
        assign cell_in_luma[k*WINDOW_W+j] = col_luma[k];
      end else begin : g_inner
        assign cell_in_pix[k*WINDOW_W+j]  = cell_pix[k*WINDOW_W+j+1];
        assign cell_in_luma[k*WINDOW_W+j] = cell_luma[k*WINDOW_W+j+1];
      end
      lmw_cell u_cell (
        .clk      (clk),
        .shift_en (adv && s1_tag_r.fetch),
        .pix_in   (cell_in_pix[k*WINDOW_W+j]),
        .luma_in  (cell_in_luma[k*WINDOW_W+j]),
        .pix_out  (cell_pix[k*WINDOW_W+j]),
        .luma_out (cell_luma[k*WINDOW_W+j])
      );
    end
  end

  // Rank selection over the completed window.
  lmw_rank #(
    .N      (N),
    .TARGET (TARGET),
    .CENTER (TARGET)
  ) u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tag_in  (s2_tag_r),
    .pix     (cell_pix),
    .luma    (cell_luma),
    .tag_out (rk_tag),
    .pix_out (rk_pix)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rk_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= rk_pix;
      out_last_r  <= rk_tag.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

  // The pending count always stays inside the line store.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r < PW'(HD))
    else $error("pending count exceeds line store depth");

  // A flush with nothing pending starts no fetch.
  a_idle_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser && (pending_r == '0)) |=> !s1_tag_r.fetch)
    else $error("flush with nothing pending started a fetch");

  // A stalled output freezes the window cells.
  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cell_pix))
    else $error("window moved while the output was stalled");

  // A rank result always enters the output register when the pipeline advances.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rk_tag.emit) |=> out_valid_r)
    else $error("rank result lost before the output register");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the luma median window filter
// A directed table covers reset geometry, extreme pixels, flushes and luma
// ties; random frames of many sizes, including the extreme register values,
// follow. Every output transfer is compared with a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
  import lmw_pkg::*;

  localparam int WIN_W      = WIN_W_DEF;
  localparam int WIN_H      = WIN_H_DEF;
  localparam int MAX_W      = MAX_WIDTH_DEF;
  localparam int HIST_D     = WIN_H * MAX_W;
  localparam int WIN_N      = WIN_W * WIN_H;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int EXTREME_ITEMS = 330;
  localparam int EXTREME_CAP = 48;

  typedef enum {ROW_PIXEL, ROW_FLUSH, ROW_GEOM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] pix;
    int          w;
    int          h;
    bit          typed;
    logic [31:0] exp_pix;
    bit          exp_last;
  } dir_row_t;

  typedef struct {
    logic [31:0] pix;
    bit          last;
  } out_pix_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata;   // pixel_in [31:0]
  logic              in_tuser;   // is_flush [0]
  logic              out_tvalid;
  logic              out_tready;
  logic [PIX_W-1:0]  out_tdata;  // pixel_out [31:0]
  logic              out_tlast;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  luma_median_window_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predictor state.
  logic [31:0] line_hist [HIST_D];
  bit          hist_valid [HIST_D];
  int          geo_w_reg, geo_h_reg;
  int          in_col, in_row, out_col, out_row, pending_cnt, wr_ptr;
  out_pix_t    expected_px [$];

  int send_idle, recv_idle;
  int items_sent, results_seen, frames_done, flushes_mid, errors;
  int stall_cnt;

  function automatic int eff_w();
    if (geo_w_reg == 0) return 1;
    if (geo_w_reg > MAX_W) return MAX_W;
    return geo_w_reg;
  endfunction

  function automatic int eff_h();
    return (geo_h_reg == 0) ? 1 : geo_h_reg;
  endfunction

  function automatic int pix_luma(logic [31:0] p);
    return 77 * int'(p[31:24]) + 150 * int'(p[23:16]) + 29 * int'(p[15:8]);
  endfunction

  function automatic int hist_pos(int base, int off);
    return ((base + off) % HIST_D + HIST_D) % HIST_D;
  endfunction

  // Next raster position: row in the upper half, column in the lower half.
  function automatic logic [31:0] next_pos(int c, int r, int w, int h);
    if (c + 1 >= w) return {((r + 1 >= h) ? 16'd0 : 16'(r + 1)), 16'd0};
    return {16'(r), 16'(c + 1)};
  endfunction

  function automatic int out_base();
    return (wr_ptr + HIST_D - (pending_cnt % HIST_D)) % HIST_D;
  endfunction

  function automatic bit window_inner();
    int w, h;
    w = eff_w();
    h = eff_h();
    return out_col >= WIN_W / 2 && out_col + WIN_W / 2 < w &&
           out_row >= WIN_H / 2 && out_row + WIN_H / 2 < h;
  endfunction

  function automatic int win_off(int i, int j);
    return (i - WIN_H / 2) * eff_w() + (j - WIN_W / 2);
  endfunction

  // A flush must not make the window read line store entries never written.
  function automatic bit flush_safe();
    int base;
    if (pending_cnt == 0 || !window_inner()) return 1'b1;
    base = out_base();
    for (int i = 0; i < WIN_H; i++)
      for (int j = 0; j < WIN_W; j++)
        if (!hist_valid[hist_pos(base, win_off(i, j))]) return 1'b0;
    return 1'b1;
  endfunction

  // Produce the next output pixel and queue it.
  function automatic void emit_pixel();
    int          base, rank, li;
    logic [31:0] win [WIN_N];
    logic [31:0] res;
    logic [31:0] np;
    out_pix_t    o;
    base = out_base();
    res = line_hist[base];
    o.last = (out_col + 1 >= eff_w()) && (out_row + 1 >= eff_h());
    if (window_inner()) begin
      for (int i = 0; i < WIN_H; i++)
        for (int j = 0; j < WIN_W; j++)
          win[i * WIN_W + j] = line_hist[hist_pos(base, win_off(i, j))];
      // Stable rank: equal lumas keep window order.
      for (int i = 0; i < WIN_N; i++) begin
        li = pix_luma(win[i]);
        rank = 0;
        for (int j = 0; j < WIN_N; j++)
          if (pix_luma(win[j]) < li || (pix_luma(win[j]) == li && j < i)) rank++;
        if (rank == (WIN_H / 2) * WIN_W + WIN_W / 2) res = win[i];
      end
    end
    o.pix = res;
    expected_px.push_back(o);
    np = next_pos(out_col, out_row, eff_w(), eff_h());
    out_col = np[15:0];
    out_row = np[31:16];
    pending_cnt--;
  endfunction

  // Apply one accepted input item; returns 1 if it yields a pixel.
  function automatic bit accept_item(bit fl, logic [31:0] px);
    int          lag;
    logic [31:0] np;
    lag = (WIN_H - 1 - WIN_H / 2) * eff_w() + (WIN_W - 1 - WIN_W / 2);
    if (fl) begin
      if (pending_cnt == 0) return 1'b0;
      emit_pixel();
      return 1'b1;
    end
    line_hist[wr_ptr] = px;
    hist_valid[wr_ptr] = 1'b1;
    wr_ptr = (wr_ptr + 1) % HIST_D;
    np = next_pos(in_col, in_row, eff_w(), eff_h());
    in_col = np[15:0];
    in_row = np[31:16];
    pending_cnt++;
    if (pending_cnt > lag) begin
      emit_pixel();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drive one input item and wait for its transfer.
  task automatic send_item(bit fl, logic [31:0] px, output bit produced);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fl;
    do @(posedge clk); while (!in_tready);
    produced = accept_item(fl, px);
    items_sent++;
  endtask

  task automatic send_plain(bit fl, logic [31:0] px);
    bit p;
    send_item(fl, px, p);
  endtask

  // Hold the sender until every expected pixel is out, then let the pipe drain.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both geometry registers while the block is idle.
  task automatic set_geometry(int w, int h);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_DW'(w);
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_DW'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    geo_w_reg = w & 12'hFFF;
    geo_h_reg = h & 13'h1FFF;
  endtask

  // A frame with random content, mid-frame flushes and a final flush; at most
  // limit pixels of it are sent.
  task automatic run_frame(int w, int h, int limit);
    logic [31:0] palette [4];
    int          mode, n;
    set_geometry(w, h);
    mode = $urandom_range(2);
    for (int k = 0; k < 4; k++) palette[k] = $urandom;
    n = eff_w() * eff_h();
    if (limit < n) n = limit;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0 && flush_safe()) begin
        if (pending_cnt != 0) flushes_mid++;
        send_plain(1'b1, $urandom);
      end
      case (mode)
        0: send_plain(1'b0, $urandom);
        1: send_plain(1'b0, palette[$urandom_range(3)]);
        default: send_plain(1'b0, {palette[0][31:8], 8'($urandom)});
      endcase
    end
    while (pending_cnt != 0) send_plain(1'b1, $urandom);
    frames_done++;
  endtask

  // Output side: random stalls at the falling edge, checks at the rising edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    out_pix_t e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("luma_median_window_filter: mismatch");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected pixel %h last %b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          e = expected_px.pop_front();
          if (out_tdata !== e.pix || out_tlast !== e.last) begin
            $display("%0t: expected pixel %h last %b, got pixel %h last %b",
                     $time, e.pix, e.last, out_tdata, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  dir_row_t dir_rows [$];

  function automatic dir_row_t mk_row(row_kind_t k, logic [31:0] px, bit typed,
                                      logic [31:0] ep, bit el);
    dir_row_t r;
    r.kind = k; r.pix = px; r.w = 0; r.h = 0;
    r.typed = typed; r.exp_pix = ep; r.exp_last = el;
    return r;
  endfunction

  function automatic dir_row_t mk_geom(int w, int h);
    dir_row_t r;
    r = mk_row(ROW_GEOM, '0, 1'b0, '0, 1'b0);
    r.w = w; r.h = h;
    return r;
  endfunction

  initial begin
    logic [31:0] first_px [5];
    bit          got;
    out_pix_t    t;
    int          sw, sh;

    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    geo_w_reg = FRAME_WIDTH_RST; geo_h_reg = FRAME_HEIGHT_RST;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending_cnt = 0; wr_ptr = 0;
    for (int k = 0; k < HIST_D; k++) hist_valid[k] = 1'b0;
    items_sent = 0; results_seen = 0; frames_done = 0; flushes_mid = 0;
    errors = 0; stall_cnt = 0;
    send_idle = 32; recv_idle = 60;

    // Directed table: reset geometry passes row zero straight through.
    first_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8080_8080,
                 32'h0102_0304};
    dir_rows.push_back(mk_row(ROW_FLUSH, 32'hDEAD_BEEF, 1'b0, '0, 1'b0));
    foreach (first_px[k]) dir_rows.push_back(mk_row(ROW_PIXEL, first_px[k], 1'b0, '0, 1'b0));
    foreach (first_px[k]) dir_rows.push_back(mk_row(ROW_FLUSH, '0, 1'b1, first_px[k], 1'b0));
    // A 1 x 1 frame realigns the raster counters; its pixel is the frame end.
    dir_rows.push_back(mk_geom(1, 1));
    dir_rows.push_back(mk_row(ROW_PIXEL, 32'hA5A5_A5A5, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(ROW_FLUSH, '0, 1'b1, 32'hA5A5_A5A5, 1'b1));
    dir_rows.push_back(mk_row(ROW_FLUSH, '0, 1'b0, '0, 1'b0));
    // A 3 x 3 frame of equal luma: the tie keeps the center pixel.
    dir_rows.push_back(mk_geom(3, 3));
    for (int k = 0; k < 9; k++)
      dir_rows.push_back(mk_row(ROW_PIXEL, {24'h10_2030, 8'(k)}, 1'b0, '0, 1'b0));
    for (int k = 0; k < 4; k++) dir_rows.push_back(mk_row(ROW_FLUSH, '0, 1'b0, '0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_GEOM) begin
        set_geometry(dir_rows[k].w, dir_rows[k].h);
      end else begin
        send_item(dir_rows[k].kind == ROW_FLUSH, dir_rows[k].pix, got);
        if (got && dir_rows[k].typed) begin
          void'(expected_px.pop_back());
          t.pix = dir_rows[k].exp_pix;
          t.last = dir_rows[k].exp_last;
          expected_px.push_back(t);
        end
      end
    end

    // Random frames of small sizes, three idling phases.
    while (items_sent < RANDOM_ITEMS - EXTREME_ITEMS) begin
      if (items_sent > 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0; recv_idle = 0;
      end else if (items_sent > RANDOM_ITEMS / 3) begin
        send_idle = 60; recv_idle = 32;
      end
      sw = $urandom_range(9, 1);
      sh = $urandom_range(9, 1);
      if ($urandom_range(3) == 0) begin
        sw = 3; sh = 3;
      end
      run_frame(sw, sh, sw * sh);
    end

    // Extreme register values; the large ones send only the start of a frame.
    send_idle = 0; recv_idle = 0;
    run_frame(0, 0, EXTREME_CAP);
    run_frame(0, 4, EXTREME_CAP);
    run_frame(5, 0, EXTREME_CAP);
    run_frame(4095, 2, EXTREME_CAP);
    run_frame(2048, 3, EXTREME_CAP);
    run_frame(2048, 1, EXTREME_CAP / 3 * 2);
    run_frame(1, 8191, EXTREME_CAP / 3 * 2);
    // A single pixel frame brings the raster counters back to the origin.
    run_frame(1, 1, 1);
    run_frame(3, 3, 9);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d items in %0d frames, %0d pixels out, %0d mid-frame flushes.",
             items_sent, frames_done, results_seen, flushes_mid);
    $display("Frames from 1 x 1 up, plus starts of frames at zero and oversize geometry.");
    if (errors == 0 && expected_px.size() == 0) begin
      $display("luma_median_window_filter: match");
    end else begin
      $display("luma_median_window_filter: mismatch");
    end
    $finish;
  end

endmodule
